@@ hdl/teup_pkg.sv @@
// shared types and byte constants for the terminal escape and utf-8 parser
package teup_pkg;

  typedef enum logic [3:0] {
    ST_GROUND  = 4'd0,
    ST_U8B1    = 4'd1,
    ST_U8B2    = 4'd2,
    ST_U8B3    = 4'd3,
    ST_ESC1    = 4'd4,
    ST_ESC2    = 4'd5,
    ST_CSI1    = 4'd6,
    ST_CSI2    = 4'd7,
    ST_CSIIGN  = 4'd8,
    ST_CSIPAR  = 4'd9,
    ST_OSC     = 4'd10
  } state_e;

  typedef enum logic [3:0] {
    AC_NONE    = 4'd0,
    AC_EXEC    = 4'd1,
    AC_PRINT   = 4'd2,
    AC_WIDE    = 4'd3,
    AC_GETB2   = 4'd4,
    AC_GETB3   = 4'd5,
    AC_GETB4   = 4'd6,
    AC_U8ERR   = 4'd7,
    AC_CLEAR   = 4'd8,
    AC_ESCDISP = 4'd9,
    AC_INTER   = 4'd10,
    AC_CSIDISP = 4'd11,
    AC_PRIV    = 4'd12,
    AC_PARAM   = 4'd13,
    AC_OSCPUT  = 4'd14,
    AC_OSCEND  = 4'd15
  } action_e;

  localparam logic [7:0] ByteLead4 = 8'hf0;
  localparam logic [7:0] ByteLead3 = 8'he0;
  localparam logic [7:0] ByteLead2 = 8'hc0;
  localparam logic [7:0] ByteTilde = 8'h7e;
  localparam logic [7:0] ByteBel   = 8'h07;
  localparam logic [7:0] ByteEsc   = 8'h1b;
  localparam logic [7:0] ByteSub   = 8'h1a;
  localparam logic [7:0] ByteCan   = 8'h18;
  localparam logic [7:0] ByteCsi   = 8'h5b;
  localparam logic [7:0] ByteOsc   = 8'h5d;
  localparam logic [7:0] ByteColon = 8'h3a;

endpackage

@@ hdl/teup_decode.sv @@
// next state and action for one byte in the current parser state
module teup_decode (
  input  teup_pkg::state_e  state_i,
  input  logic [7:0]        byte_i,
  output teup_pkg::state_e  next_state_o,
  output teup_pkg::action_e action_o
);
  import teup_pkg::*;

  logic is_ctrl, is_cont, is_final, is_inter, is_param, is_priv, is_dispatch;
  logic in_utf8;

  always_comb begin
    is_ctrl     = (byte_i <= 8'h1f);
    is_cont     = (byte_i >= 8'h80) || (byte_i <= 8'h3f);
    is_final    = (byte_i >= 8'h30) && (byte_i <= ByteTilde);
    is_inter    = (byte_i >= 8'h20) && (byte_i <= 8'h2f);
    is_param    = (byte_i >= 8'h30) && (byte_i <= 8'h3b);
    is_priv     = (byte_i >= 8'h3c) && (byte_i <= 8'h3f);
    is_dispatch = (byte_i >= 8'h40) && (byte_i <= ByteTilde);
    in_utf8     = (state_i == ST_U8B1) || (state_i == ST_U8B2) || (state_i == ST_U8B3);
  end

  always_comb begin
    next_state_o = state_i;
    action_o     = AC_NONE;
    if (!in_utf8 && byte_i == ByteEsc) begin
      next_state_o = ST_ESC1;
      action_o     = AC_CLEAR;
    end else if (!in_utf8 && (byte_i == ByteSub || byte_i == ByteCan)) begin
      next_state_o = ST_GROUND;
      action_o     = AC_EXEC;
    end else begin
      case (state_i)
        ST_U8B1, ST_U8B2, ST_U8B3: begin
          if (is_cont) begin
            case (state_i)
              ST_U8B1: begin
                next_state_o = ST_GROUND;
                action_o     = AC_WIDE;
              end
              ST_U8B2: begin
                next_state_o = ST_U8B1;
                action_o     = AC_GETB2;
              end
              default: begin
                next_state_o = ST_U8B2;
                action_o     = AC_GETB3;
              end
            endcase
          end else begin
            next_state_o = ST_GROUND;
            action_o     = AC_U8ERR;
          end
        end
        ST_ESC1: begin
          if (byte_i == ByteOsc) begin
            next_state_o = ST_OSC;
          end else if (byte_i == ByteCsi) begin
            next_state_o = ST_CSI1;
          end else if (is_final) begin
            next_state_o = ST_GROUND;
            action_o     = AC_ESCDISP;
          end else if (is_inter) begin
            next_state_o = ST_ESC2;
            action_o     = AC_INTER;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_ESC2: begin
          if (is_final) begin
            next_state_o = ST_GROUND;
            action_o     = AC_ESCDISP;
          end else if (is_inter) begin
            next_state_o = ST_GROUND;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_CSI1: begin
          if (is_dispatch) begin
            next_state_o = ST_GROUND;
            action_o     = AC_CSIDISP;
          end else if (is_priv) begin
            next_state_o = ST_CSIPAR;
            action_o     = AC_PRIV;
          end else if (byte_i == ByteColon) begin
            next_state_o = ST_CSIIGN;
          end else if (is_param) begin
            next_state_o = ST_CSIPAR;
            action_o     = AC_PARAM;
          end else if (is_inter) begin
            next_state_o = ST_CSI2;
            action_o     = AC_INTER;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_CSI2: begin
          if (is_dispatch) begin
            next_state_o = ST_GROUND;
            action_o     = AC_CSIDISP;
          end else if (is_inter || is_param || is_priv) begin
            next_state_o = ST_CSIIGN;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_CSIIGN: begin
          if (is_dispatch) begin
            next_state_o = ST_GROUND;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_CSIPAR: begin
          if (is_dispatch) begin
            next_state_o = ST_GROUND;
            action_o     = AC_CSIDISP;
          end else if (is_priv || byte_i == ByteColon) begin
            next_state_o = ST_CSIIGN;
          end else if (is_param) begin
            action_o = AC_PARAM;
          end else if (is_inter) begin
            next_state_o = ST_CSI2;
            action_o     = AC_INTER;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end
        end
        ST_OSC: begin
          if (byte_i == ByteBel) begin
            next_state_o = ST_GROUND;
            action_o     = AC_OSCEND;
          end else if (!is_ctrl) begin
            action_o = AC_OSCPUT;
          end
        end
        default: begin
          // ground, and any code outside the state list behaves as ground
          next_state_o = ST_GROUND;
          if (byte_i >= ByteLead4 && byte_i <= 8'hf7) begin
            next_state_o = ST_U8B3;
            action_o     = AC_GETB4;
          end else if (byte_i >= ByteLead3 && byte_i <= 8'hef) begin
            next_state_o = ST_U8B2;
            action_o     = AC_GETB3;
          end else if (byte_i >= ByteLead2 && byte_i <= 8'hdf) begin
            next_state_o = ST_U8B1;
            action_o     = AC_GETB2;
          end else if (byte_i >= 8'h20 && byte_i <= 8'h7f) begin
            action_o = AC_PRINT;
          end else if (is_ctrl) begin
            action_o = AC_EXEC;
          end else begin
            action_o = AC_U8ERR;
          end
        end
      endcase
    end
  end

endmodule

@@ hdl/terminal_escape_utf8_parser_core.sv @@
// top level of the terminal escape sequence and utf-8 byte parser
// One input byte in, one action out, for every byte. The block takes a byte in every cycle while
// the output side keeps taking actions: a byte lands in an input register, is decoded against the
// parser state and the action goes into the result register, so the sustained rate is one byte per
// cycle while the output is not stalled, set by the single decode step between those registers.
// Ready on the input falls only when both registers hold beats that the output side has
// not yet taken. Reset puts the parser in the ground state.
module terminal_escape_utf8_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] action_o
);
  import teup_pkg::*;

  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       out_valid_q;
  action_e    action_q;
  state_e     state_q;
  state_e     state_d;
  action_e    action_d;
  logic       out_load;
  logic       advance;

  teup_decode u_decode (
    .state_i      (state_q),
    .byte_i       (byte_q),
    .next_state_o (state_d),
    .action_o     (action_d)
  );

  assign out_load    = !out_valid_q || out_ready_i;
  assign advance     = in_valid_q && out_load;
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign action_o    = action_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= ST_GROUND;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_load) begin
        out_valid_q <= in_valid_q;
      end
      if (advance) begin
        state_q <= state_d;
      end
    end
  end

  // beat registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= byte_in_i;
    end
    if (advance) begin
      action_q <= action_d;
    end
  end

endmodule

@@ tb/sv/terminal_escape_utf8_parser_core_tb.sv @@
// self-checking testbench for the terminal escape sequence and utf-8 byte parser
module terminal_escape_utf8_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import teup_pkg::*;

  typedef logic [7:0] byte_seq_t[$];

  localparam int StallLimit = 2000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] byte_in_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [3:0] action_o;

  state_e  tracked_state = ST_GROUND;
  action_e pending_actions[$];
  action_e due_action;
  int      mismatches = 0;
  int      bytes_sent = 0;
  int      quiet_cycles = 0;
  int      hold_left = 0;
  int      stall_left = 0;
  bit      tx_idle_en = 1'b1;
  bit      rx_idle_en = 1'b1;

  terminal_escape_utf8_parser_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_in_i  (byte_in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .action_o   (action_o)
  );

  always #1 clk_i = ~clk_i;

  // state and action that one byte causes
  function automatic void decode_byte(input state_e st, input logic [7:0] b,
                                      output state_e nst, output action_e act);
    logic in_utf8;
    in_utf8 = (st == ST_U8B1) || (st == ST_U8B2) || (st == ST_U8B3);
    nst = st;
    act = AC_NONE;
    if (!in_utf8 && b == ByteEsc) begin
      nst = ST_ESC1;
      act = AC_CLEAR;
    end else if (!in_utf8 && (b == ByteSub || b == ByteCan)) begin
      nst = ST_GROUND;
      act = AC_EXEC;
    end else begin
      case (st)
        ST_U8B1, ST_U8B2, ST_U8B3: begin
          if (b >= 8'h80 || b <= 8'h3f) begin
            nst = state_e'(st - 4'd1);
            if (st == ST_U8B1) act = AC_WIDE;
            else if (st == ST_U8B2) act = AC_GETB2;
            else act = AC_GETB3;
          end else begin
            nst = ST_GROUND;
            act = AC_U8ERR;
          end
        end
        ST_ESC1: begin
          if (b == ByteOsc) nst = ST_OSC;
          else if (b == ByteCsi) nst = ST_CSI1;
          else if (b >= 8'h30 && b <= ByteTilde) begin
            nst = ST_GROUND;
            act = AC_ESCDISP;
          end else if (b >= 8'h20 && b <= 8'h2f) begin
            nst = ST_ESC2;
            act = AC_INTER;
          end else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_ESC2: begin
          if (b >= 8'h30 && b <= ByteTilde) begin
            nst = ST_GROUND;
            act = AC_ESCDISP;
          end else if (b >= 8'h20 && b <= 8'h2f) nst = ST_GROUND;
          else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_CSI1: begin
          if (b >= 8'h40 && b <= ByteTilde) begin
            nst = ST_GROUND;
            act = AC_CSIDISP;
          end else if (b >= 8'h3c && b <= 8'h3f) begin
            nst = ST_CSIPAR;
            act = AC_PRIV;
          end else if (b == ByteColon) nst = ST_CSIIGN;
          else if (b >= 8'h30 && b <= 8'h3b) begin
            nst = ST_CSIPAR;
            act = AC_PARAM;
          end else if (b >= 8'h20 && b <= 8'h2f) begin
            nst = ST_CSI2;
            act = AC_INTER;
          end else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_CSI2: begin
          if (b >= 8'h40 && b <= ByteTilde) begin
            nst = ST_GROUND;
            act = AC_CSIDISP;
          end else if (b >= 8'h20 && b <= 8'h3f) nst = ST_CSIIGN;
          else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_CSIIGN: begin
          if (b >= 8'h40 && b <= ByteTilde) nst = ST_GROUND;
          else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_CSIPAR: begin
          if (b >= 8'h40 && b <= ByteTilde) begin
            nst = ST_GROUND;
            act = AC_CSIDISP;
          end else if ((b >= 8'h3c && b <= 8'h3f) || b == ByteColon) nst = ST_CSIIGN;
          else if (b >= 8'h30 && b <= 8'h3b) act = AC_PARAM;
          else if (b >= 8'h20 && b <= 8'h2f) begin
            nst = ST_CSI2;
            act = AC_INTER;
          end else if (b <= 8'h1f) act = AC_EXEC;
        end
        ST_OSC: begin
          if (b == ByteBel) begin
            nst = ST_GROUND;
            act = AC_OSCEND;
          end else if (b > 8'h1f) act = AC_OSCPUT;
        end
        default: begin
          if (b >= ByteLead4 && b <= 8'hf7) begin
            nst = ST_U8B3;
            act = AC_GETB4;
          end else if (b >= ByteLead3 && b <= 8'hef) begin
            nst = ST_U8B2;
            act = AC_GETB3;
          end else if (b >= ByteLead2 && b <= 8'hdf) begin
            nst = ST_U8B1;
            act = AC_GETB2;
          end else if (b >= 8'h20 && b <= 8'h7f) act = AC_PRINT;
          else if (b <= 8'h1f) act = AC_EXEC;
          else act = AC_U8ERR;
        end
      endcase
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [3:0] want,
                                 input logic [3:0] got);
    $display("%0t: %s: expected action %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  // one byte per call; valid stays high after the beat so the next call can follow on
  task automatic send_byte(input logic [7:0] b);
    int      gap;
    state_e  nst;
    action_e act;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    byte_in_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    decode_byte(tracked_state, b, nst, act);
    tracked_state = nst;
    pending_actions.push_back(act);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_actions.size() != 0);
  endtask

  function automatic logic [7:0] any_cont_byte();
    if ($urandom_range(0, 1) == 0) return 8'($urandom_range(8'h00, 8'h3f));
    return 8'($urandom_range(8'h80, 8'hff));
  endfunction

  // mostly well-formed sequences with random content, the rest broken ones and noise
  task automatic make_sequence(output byte_seq_t seq);
    int kind;
    int n;
    seq  = {};
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      n = $urandom_range(1, 6);
      repeat (n) seq.push_back(8'($urandom_range(8'h20, 8'h7f)));
    end else if (kind < 45) begin
      n = $urandom_range(2, 4);
      if (n == 2) seq.push_back(8'($urandom_range(ByteLead2, 8'hdf)));
      else if (n == 3) seq.push_back(8'($urandom_range(ByteLead3, 8'hef)));
      else seq.push_back(8'($urandom_range(ByteLead4, 8'hf7)));
      repeat (n - 1) begin
        if ($urandom_range(0, 7) == 0) seq.push_back(any_cont_byte());
        else seq.push_back(8'($urandom_range(8'h80, 8'hbf)));
      end
    end else if (kind < 60) begin
      seq.push_back(ByteEsc);
      seq.push_back(ByteCsi);
      if ($urandom_range(0, 2) == 0) seq.push_back(8'($urandom_range(8'h3c, 8'h3f)));
      n = $urandom_range(0, 4);
      repeat (n) seq.push_back(8'($urandom_range(8'h30, 8'h3b)));
      if ($urandom_range(0, 4) == 0) seq.push_back(8'($urandom_range(8'h20, 8'h2f)));
      if ($urandom_range(0, 7) == 0) seq.push_back(8'($urandom_range(8'h00, 8'h1f)));
      seq.push_back(8'($urandom_range(8'h40, ByteTilde)));
    end else if (kind < 70) begin
      seq.push_back(ByteEsc);
      seq.push_back(ByteOsc);
      n = $urandom_range(0, 6);
      repeat (n) begin
        if ($urandom_range(0, 3) == 0) seq.push_back(8'($urandom_range(8'h00, 8'h1f)));
        else seq.push_back(8'($urandom_range(8'h20, 8'hff)));
      end
      case ($urandom_range(0, 5))
        0: seq.push_back(ByteEsc);
        1: seq.push_back(ByteCan);
        2: seq.push_back(ByteSub);
        default: seq.push_back(ByteBel);
      endcase
    end else if (kind < 78) begin
      seq.push_back(ByteEsc);
      if ($urandom_range(0, 5) == 0) seq.push_back(8'($urandom_range(8'h00, 8'h1f)));
      if ($urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 2);
        repeat (n) seq.push_back(8'($urandom_range(8'h20, 8'h2f)));
      end
      seq.push_back(8'($urandom_range(8'h30, ByteTilde)));
    end else if (kind < 86) begin
      seq.push_back(8'($urandom_range(8'h00, 8'h1f)));
    end else if (kind < 93) begin
      // sequence cut short by an arbitrary byte
      case ($urandom_range(0, 2))
        0: seq.push_back(ByteEsc);
        1: begin
          seq.push_back(ByteEsc);
          seq.push_back(ByteCsi);
        end
        default: seq.push_back(8'($urandom_range(ByteLead2, 8'hf7)));
      endcase
      seq.push_back(8'($urandom_range(0, 255)));
    end else begin
      n = $urandom_range(1, 4);
      repeat (n) seq.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random(input int count);
    int        goal;
    byte_seq_t seq;
    goal = bytes_sent + count;
    while (bytes_sent < goal) begin
      make_sequence(seq);
      foreach (seq[i]) send_byte(seq[i]);
    end
  endtask

  task automatic test_directed();
    byte_seq_t script;
    script = {8'h00, 8'hff, 8'h7f, 8'h80,           // ground extremes and stray bytes
              8'hc2, 8'h41,                         // broken two-byte char
              8'hf7, ByteEsc, 8'h00, 8'hff,         // four-byte char, controls as continuation
              ByteEsc, ByteCsi, 8'h3c, 8'h31, 8'h3b, 8'h20, 8'h40,
              ByteEsc, ByteCsi, ByteColon, 8'h41,   // csi ignore
              ByteEsc, ByteOsc, 8'h41, 8'h01, ByteBel,
              ByteEsc, 8'h28, 8'h42,
              ByteEsc, ByteSub, ByteCan};
    foreach (script[i]) send_byte(script[i]);
  endtask

  task automatic test_random_traffic();
    send_random(1300);
  endtask

  // output side held off while bytes keep coming, so the input has to stall
  task automatic test_receiver_hold();
    tx_idle_en = 1'b0;
    hold_left  = 64;
    send_random(60);
    tx_idle_en = 1'b1;
  endtask

  task automatic test_drain_pause();
    send_random(40);
    wait_for_results();
    send_random(20);
  endtask

  task automatic test_full_rate();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    send_random(400);
  endtask

  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        stall_left = $urandom_range(0, 7);
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_actions.size() == 0) begin
        report_mismatch("beat with no action pending", 4'h0, action_o);
      end else begin
        due_action = pending_actions.pop_front();
        if (action_o !== due_action) report_mismatch("action", due_action, action_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("terminal_escape_utf8_parser_core: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_random_traffic();
    test_receiver_hold();
    test_drain_pause();
    test_full_rate();
    wait_for_results();
    repeat (8) @(negedge clk_i);
    if (mismatches == 0 && pending_actions.size() == 0) begin
      $display("terminal_escape_utf8_parser_core: match");
    end else begin
      $display("terminal_escape_utf8_parser_core: mismatch");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/teup_pkg.sv
hdl/teup_decode.sv
hdl/terminal_escape_utf8_parser_core.sv
tb/sv/terminal_escape_utf8_parser_core_tb.sv
